// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

    // byte width of every symbol, and the size of the full symbol alphabet
    localparam int SYM_W    = 8;
    localparam int SYM_NUM  = 256;

    // pad and substitution bytes
    localparam logic [SYM_W-1:0] PAD_DOUBLE = 8'h00;
    localparam logic [SYM_W-1:0] PAD_ODD    = 8'h03;
    localparam logic [SYM_W-1:0] SPACE_BYTE = 8'h20;

    typedef enum logic [1:0] {
        ACT_KEY     = 2'd0,
        ACT_FINISH  = 2'd1,
        ACT_ENCRYPT = 2'd2,
        ACT_DECRYPT = 2'd3
    } bpc_action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_SQR,
        S_FILL,
        S_HOLD
    } bpc_state_t;

    typedef struct packed {
        bpc_action_t      action;
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic             b_missing;
    } bpc_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_a;
        logic [SYM_W-1:0] out_b;
        logic             status;
    } bpc_out_t;

endpackage

// ===== rtl/bpc_pair_rule.sv =====
module bpc_pair_rule
    import bpc_pkg::*;
#(
    parameter int GRID_SIDE = 16
)
(
    input  logic [$clog2(GRID_SIDE)-1:0]             row_a,
    input  logic [$clog2(GRID_SIDE)-1:0]             col_a,
    input  logic [$clog2(GRID_SIDE)-1:0]             row_b,
    input  logic [$clog2(GRID_SIDE)-1:0]             col_b,
    input  logic                                     decrypt,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   cell_a,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   cell_b
);

    localparam int ROW_W = $clog2(GRID_SIDE);
    localparam int CELL_W = $clog2(GRID_SIDE*GRID_SIDE);
    localparam logic [ROW_W-1:0] LAST = ROW_W'(GRID_SIDE - 1);

    // one step along a row or column, wrapping at the grid edge
    function automatic logic [ROW_W-1:0] shift_one(input logic [ROW_W-1:0] v,
                                                   input logic dec);
        logic [ROW_W-1:0] r;
        if (dec)
        begin
            r = (v == '0) ? LAST : v - ROW_W'(1);
        end
        else
        begin
            r = (v == LAST) ? '0 : v + ROW_W'(1);
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] c);
        return CELL_W'(r) * CELL_W'(GRID_SIDE) + CELL_W'(c);
    endfunction

    logic same_row;
    logic same_col;

    assign same_row = (row_a == row_b);
    assign same_col = (col_a == col_b);

    // rectangle, row shift (also for the same cell) or column shift
    always_comb
    begin
        if (!same_row && !same_col)
        begin
            cell_a = cell_of(row_a, col_b);
            cell_b = cell_of(row_b, col_a);
        end
        else if (same_row)
        begin
            cell_a = cell_of(row_a, shift_one(col_a, decrypt));
            cell_b = cell_of(row_b, shift_one(col_b, decrypt));
        end
        else
        begin
            cell_a = cell_of(shift_one(row_a, decrypt), col_a);
            cell_b = cell_of(shift_one(row_b, decrypt), col_b);
        end
    end

endmodule

// ===== rtl/byte_playfair_cipher_16x16.sv =====
// result path: a key byte or refused pair goes straight to the output register, an encrypt
// or decrypt pair first through the place memory read, then the square memory read
// finish: sweeps one symbol value per cycle until the square is full or all 256 are swept
// a new request is taken only in idle, once the last result has reached the output register
// reset: control state and the used bits clear at once; square and place memories
// are not cleared and are written by key entry and the finish sweep
module byte_playfair_cipher_16x16
    import bpc_pkg::*;
#(
    parameter int GRID_SIDE = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bpc_in_t  req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bpc_out_t rsp_data
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ROW_W  = $clog2(GRID_SIDE);
    localparam int CELL_W = $clog2(CELLS);
    localparam int POS_W  = 2 * ROW_W;
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  LAST_COL  = ROW_W'(GRID_SIDE - 1);

    // memories
    logic [SYM_W-1:0] square_mem [CELLS];
    logic [POS_W-1:0] place_mem  [SYM_NUM];

    bpc_state_t        state_reg, state_next;
    logic [SYM_NUM-1:0] used_reg, used_next;
    logic [CELL_W-1:0] fill_cell_reg, fill_cell_next;
    logic [ROW_W-1:0]  fill_row_reg, fill_row_next;
    logic [ROW_W-1:0]  fill_col_reg, fill_col_next;
    logic              full_reg, full_next;
    logic              ready_reg, ready_next;
    logic [SYM_W-1:0]  sweep_reg, sweep_next;
    logic              dec_reg, dec_next;
    logic [SYM_W-1:0]  sym_a_reg, sym_a_next;
    logic [SYM_W-1:0]  sym_b_reg, sym_b_next;
    bpc_out_t          res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    bpc_out_t          rsp_data_reg, rsp_data_next;

    logic [POS_W-1:0]  place_a_reg, place_b_reg;
    logic [SYM_W-1:0]  square_a_reg, square_b_reg;

    // memory control
    logic              put_en;
    logic [SYM_W-1:0]  put_sym;
    logic              place_rd_en;
    logic              square_rd_en;
    logic [CELL_W-1:0] cell_a, cell_b;

    // decoded positions, unused symbols sit at cell 0
    logic [POS_W-1:0]  pos_a, pos_b;
    logic              slot_free;
    logic              done_now;
    bpc_out_t          res_now;
    logic [SYM_W-1:0]  enc_b;
    logic [SYM_W-1:0]  dec_b;

    assign pos_a = used_reg[sym_a_reg] ? place_a_reg : '0;
    assign pos_b = used_reg[sym_b_reg] ? place_b_reg : '0;

    bpc_pair_rule #(
        .GRID_SIDE (GRID_SIDE)
    ) u_pair_rule (
        .row_a   (pos_a[POS_W-1:ROW_W]),
        .col_a   (pos_a[ROW_W-1:0]),
        .row_b   (pos_b[POS_W-1:ROW_W]),
        .col_b   (pos_b[ROW_W-1:0]),
        .decrypt (dec_reg),
        .cell_a  (cell_a),
        .cell_b  (cell_b)
    );

    // square and place memories
    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            square_mem[fill_cell_reg] <= put_sym;
            place_mem[put_sym]        <= {fill_row_reg, fill_col_reg};
        end
        if (place_rd_en)
        begin
            place_a_reg <= place_mem[sym_a_next];
            place_b_reg <= place_mem[sym_b_next];
        end
        if (square_rd_en)
        begin
            square_a_reg <= square_mem[cell_a];
            square_b_reg <= square_mem[cell_b];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            fill_cell_reg <= '0;
            fill_row_reg  <= '0;
            fill_col_reg  <= '0;
            full_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            fill_cell_reg <= fill_cell_next;
            fill_row_reg  <= fill_row_next;
            fill_col_reg  <= fill_col_next;
            full_reg      <= full_next;
            ready_reg     <= ready_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dec_reg      <= dec_next;
        sym_a_reg    <= sym_a_next;
        sym_b_reg    <= sym_b_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // encrypt padding of the second byte
    assign enc_b = req_data.b_missing ? PAD_ODD :
                   (req_data.sym_b == req_data.sym_a) ? PAD_DOUBLE : req_data.sym_b;

    // decrypt cleanup of the second byte
    always_comb
    begin
        dec_b = square_b_reg;
        if (dec_b == PAD_DOUBLE)
        begin
            dec_b = square_a_reg;
        end
        if (dec_b == PAD_ODD)
        begin
            dec_b = SPACE_BYTE;
        end
    end

    // next state, fill counters and result
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        fill_cell_next = fill_cell_reg;
        fill_row_next  = fill_row_reg;
        fill_col_next  = fill_col_reg;
        full_next      = full_reg;
        ready_next     = ready_reg;
        sweep_next     = sweep_reg;
        dec_next       = dec_reg;
        sym_a_next     = sym_a_reg;
        sym_b_next     = sym_b_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        put_en         = 1'b0;
        put_sym        = req_data.sym_a;
        place_rd_en    = 1'b0;
        square_rd_en   = 1'b0;
        done_now       = 1'b0;
        res_now        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_data.action)
                        ACT_KEY:
                        begin
                            put_en   = !ready_reg && !full_reg && !used_reg[req_data.sym_a];
                            put_sym  = req_data.sym_a;
                            done_now = 1'b1;
                        end
                        ACT_FINISH:
                        begin
                            if (ready_reg)
                            begin
                                done_now = 1'b1;
                            end
                            else
                            begin
                                sweep_next = '0;
                                state_next = S_FILL;
                            end
                        end
                        ACT_ENCRYPT, ACT_DECRYPT:
                        begin
                            if (!ready_reg)
                            begin
                                done_now       = 1'b1;
                                res_now.status = 1'b1;
                            end
                            else
                            begin
                                dec_next    = (req_data.action == ACT_DECRYPT);
                                sym_a_next  = req_data.sym_a;
                                sym_b_next  = (req_data.action == ACT_ENCRYPT) ?
                                              enc_b : req_data.sym_b;
                                place_rd_en = 1'b1;
                                state_next  = S_POS;
                            end
                        end
                        default:
                        begin
                            done_now = 1'b1;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                square_rd_en = 1'b1;
                state_next   = S_SQR;
            end
            S_SQR:
            begin
                done_now      = 1'b1;
                res_now.out_a = square_a_reg;
                res_now.out_b = dec_reg ? dec_b : square_b_reg;
            end
            S_FILL:
            begin
                put_sym = sweep_reg;
                if (full_reg)
                begin
                    ready_next = 1'b1;
                    done_now   = 1'b1;
                end
                else
                begin
                    put_en     = !used_reg[sweep_reg];
                    sweep_next = sweep_reg + SYM_W'(1);
                    if (sweep_reg == SYM_W'(SYM_NUM - 1))
                    begin
                        ready_next = 1'b1;
                        done_now   = 1'b1;
                    end
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // place one symbol at the next free cell
        if (put_en)
        begin
            used_next[put_sym] = 1'b1;
            if (fill_cell_reg == LAST_CELL)
            begin
                full_next      = 1'b1;
                fill_cell_next = '0;
                fill_row_next  = '0;
                fill_col_next  = '0;
            end
            else
            begin
                fill_cell_next = fill_cell_reg + CELL_W'(1);
                if (fill_col_reg == LAST_COL)
                begin
                    fill_col_next = '0;
                    fill_row_next = fill_row_reg + ROW_W'(1);
                end
                else
                begin
                    fill_col_next = fill_col_reg + ROW_W'(1);
                end
            end
        end

        // hand the result to the output register or park it
        if (done_now)
        begin
            if (slot_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_data_next  = res_now;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = res_now;
                state_next = S_HOLD;
            end
        end
    end

`ifndef SYNTH
    // a finished key square stays finished
    assert property (@(posedge clk) disable iff (!rst_n) ready_reg |=> ready_reg)
        else $error("key square lost its finished flag");

    // fill cell index tracks row and column counters
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_cell_reg == CELL_W'(fill_row_reg) * CELL_W'(GRID_SIDE) + CELL_W'(fill_col_reg))
        else $error("fill cell and row/column counters disagree");

    // a refused pair carries zero bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status |-> rsp_data.out_a == '0 && rsp_data.out_b == '0)
        else $error("refused pair with nonzero bytes");

    // pairs are worked only on a finished square
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POS |-> ready_reg)
        else $error("pair lookup without a finished key square");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int SIDE         = 16;
    localparam int CELLS        = SIDE * SIDE;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAIR_ITEMS   = 950;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRE_ROWS     = 9;
    localparam int PLAN_ROWS    = 23;

    localparam bpc_out_t NONE_OUT    = '{8'h00, 8'h00, 1'b0};
    localparam bpc_out_t REFUSED_OUT = '{8'h00, 8'h00, 1'b1};

    typedef struct {
        bpc_in_t  item;
        bit       typed;
        bpc_out_t want;
    } plan_row_t;

    // directed stimulus; rows before PRE_ROWS go ahead of the random key entry
    plan_row_t plan [PLAN_ROWS] = '{
        // pairs before the square is finished are refused
        '{'{ACT_ENCRYPT, 8'h00, 8'hFF, 1'b0}, 1'b1, REFUSED_OUT},
        '{'{ACT_DECRYPT, 8'hFF, 8'h00, 1'b1}, 1'b1, REFUSED_OUT},
        '{'{ACT_ENCRYPT, 8'h55, 8'hAA, 1'b1}, 1'b1, REFUSED_OUT},
        // key bytes, one repeated
        '{'{ACT_KEY,     8'hFF, 8'h00, 1'b0}, 1'b1, NONE_OUT},
        '{'{ACT_KEY,     8'h00, 8'hFF, 1'b0}, 1'b1, NONE_OUT},
        '{'{ACT_KEY,     8'hFF, 8'hFF, 1'b1}, 1'b1, NONE_OUT},
        '{'{ACT_KEY,     8'h03, 8'h00, 1'b0}, 1'b1, NONE_OUT},
        '{'{ACT_KEY,     8'h20, 8'h00, 1'b0}, 1'b1, NONE_OUT},
        '{'{ACT_KEY,     8'hAA, 8'h55, 1'b1}, 1'b1, NONE_OUT},
        // finish, finish again, key byte after finish
        '{'{ACT_FINISH,  8'h00, 8'h00, 1'b0}, 1'b1, NONE_OUT},
        '{'{ACT_FINISH,  8'hFF, 8'hFF, 1'b1}, 1'b1, NONE_OUT},
        '{'{ACT_KEY,     8'h7E, 8'h81, 1'b0}, 1'b1, NONE_OUT},
        // encrypt extremes, doubled bytes, odd final byte, same cell
        '{'{ACT_ENCRYPT, 8'h00, 8'hFF, 1'b0}, 1'b0, NONE_OUT},
        '{'{ACT_ENCRYPT, 8'hFF, 8'h00, 1'b0}, 1'b0, NONE_OUT},
        '{'{ACT_ENCRYPT, 8'h42, 8'h42, 1'b0}, 1'b0, NONE_OUT},
        '{'{ACT_ENCRYPT, 8'h00, 8'h00, 1'b0}, 1'b0, NONE_OUT},
        '{'{ACT_ENCRYPT, 8'h03, 8'hAA, 1'b1}, 1'b0, NONE_OUT},
        '{'{ACT_ENCRYPT, 8'h03, 8'h03, 1'b1}, 1'b0, NONE_OUT},
        '{'{ACT_ENCRYPT, 8'hFF, 8'hFF, 1'b1}, 1'b0, NONE_OUT},
        // decrypt extremes and same cell
        '{'{ACT_DECRYPT, 8'h00, 8'hFF, 1'b0}, 1'b0, NONE_OUT},
        '{'{ACT_DECRYPT, 8'hFF, 8'hFF, 1'b1}, 1'b0, NONE_OUT},
        '{'{ACT_DECRYPT, 8'h55, 8'hAA, 1'b0}, 1'b0, NONE_OUT},
        '{'{ACT_DECRYPT, 8'h03, 8'h20, 1'b1}, 1'b0, NONE_OUT}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bpc_in_t  req_data  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bpc_out_t rsp_data;

    bpc_out_t cipher_result_q [$];
    int       fail_count   = 0;
    bit       calm         = 1'b0;
    bit       hold_request = 1'b0;
    int       stall_left   = 0;

    // shadow copy of the key square
    logic [7:0] sq_model  [CELLS];
    logic [7:0] pos_model [CELLS];
    bit         used_model [CELLS];
    int         key_len  = 0;
    bit         key_done = 1'b0;

    byte_playfair_cipher_16x16 #(
        .GRID_SIDE (SIDE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // a symbol missing from the square counts as cell 0
    function automatic int cell_of(input logic [7:0] s);
        return used_model[s] ? int'(pos_model[s]) % CELLS : 0;
    endfunction

    // rectangle rule, or shift along a shared row, else a shared column
    function automatic void shift_pair(input logic [7:0] a, input logic [7:0] b,
                                       input int step,
                                       output logic [7:0] oa, output logic [7:0] ob);
        int pa, pb, ra, ca, rb, cb;
        pa = cell_of(a);
        pb = cell_of(b);
        ra = pa / SIDE;
        ca = pa % SIDE;
        rb = pb / SIDE;
        cb = pb % SIDE;
        if (ra != rb && ca != cb)
        begin
            oa = sq_model[ra * SIDE + cb];
            ob = sq_model[rb * SIDE + ca];
        end
        else if (ra == rb)
        begin
            oa = sq_model[ra * SIDE + (ca + step) % SIDE];
            ob = sq_model[rb * SIDE + (cb + step) % SIDE];
        end
        else
        begin
            oa = sq_model[((ra + step) % SIDE) * SIDE + ca];
            ob = sq_model[((rb + step) % SIDE) * SIDE + cb];
        end
    endfunction

    // encrypt with padding of odd and doubled second bytes
    function automatic void seal_pair(input logic [7:0] a, input logic [7:0] b,
                                      input logic miss,
                                      output logic [7:0] oa, output logic [7:0] ob);
        logic [7:0] bb;
        bb = miss ? PAD_ODD : ((b == a) ? PAD_DOUBLE : b);
        shift_pair(a, bb, 1, oa, ob);
    endfunction

    function automatic void add_symbol(input logic [7:0] s);
        sq_model[key_len % CELLS] = s;
        pos_model[s]  = 8'(key_len);
        used_model[s] = 1'b1;
        key_len++;
    endfunction

    // updates the shadow square and returns the result the block should give
    function automatic bpc_out_t predict_cipher(input bpc_in_t it);
        bpc_out_t   r;
        logic [7:0] oa, ob;
        r = '0;
        case (it.action)
            ACT_KEY:
            begin
                if (!key_done && key_len < CELLS && !used_model[it.sym_a])
                    add_symbol(it.sym_a);
            end
            ACT_FINISH:
            begin
                if (!key_done)
                begin
                    for (int v = 0; v < 256 && key_len < CELLS; v++)
                        if (!used_model[v])
                            add_symbol(8'(v));
                    key_done = 1'b1;
                end
            end
            default:
            begin
                if (!key_done)
                    r.status = 1'b1;
                else if (it.action == ACT_ENCRYPT)
                begin
                    seal_pair(it.sym_a, it.sym_b, it.b_missing, oa, ob);
                    r.out_a = oa;
                    r.out_b = ob;
                end
                else
                begin
                    shift_pair(it.sym_a, it.sym_b, SIDE - 1, oa, ob);
                    if (ob == PAD_DOUBLE)
                        ob = oa;
                    if (ob == PAD_ODD)
                        ob = SPACE_BYTE;
                    r.out_a = oa;
                    r.out_b = ob;
                end
            end
        endcase
        return r;
    endfunction

    // offer one transaction, with a random gap ahead of it
    task automatic send_item(input bpc_in_t it, input bit typed, input bpc_out_t want);
        bpc_out_t predicted;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_cipher(it);
        cipher_result_q.push_back(typed ? want : predicted);
    endtask

    // response side: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each response transaction with the oldest expectation
    always @(posedge clk)
    begin : check_rsp
        bpc_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (cipher_result_q.size() == 0)
            begin
                $error("unexpected transaction: out_a %h out_b %h status %b",
                       rsp_data.out_a, rsp_data.out_b, rsp_data.status);
                fail_count++;
            end
            else
            begin
                want = cipher_result_q.pop_front();
                if (rsp_data.out_a !== want.out_a)
                begin
                    $error("out_a: expected %h, got %h", want.out_a, rsp_data.out_a);
                    fail_count++;
                end
                if (rsp_data.out_b !== want.out_b)
                begin
                    $error("out_b: expected %h, got %h", want.out_b, rsp_data.out_b);
                    fail_count++;
                end
                if (rsp_data.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, rsp_data.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        bpc_in_t    it;
        int         perm [CELLS];
        int         tmp, j, p, mode, pick, key_items;
        bit         full_key;
        bit         miss;
        logic [7:0] a, b, ca, cb;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PRE_ROWS; r++)
            send_item(plan[r].item, plan[r].typed, plan[r].want);

        // key entry: either every byte value in shuffled order, then overflow,
        // or a partial key of random bytes left for the finish sweep
        full_key  = ($urandom_range(0, 2) == 0);
        key_items = full_key ? CELLS + 24 : 160;
        for (int i = 0; i < CELLS; i++)
            perm[i] = i;
        for (int i = CELLS - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < key_items; i++)
        begin
            it.sym_a     = 8'($urandom);
            it.sym_b     = 8'($urandom);
            it.b_missing = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            // refused pair or a stray (often repeated) key byte in between
            if (pick == 0)
            begin
                it.action = ($urandom_range(0, 1) != 0) ? ACT_ENCRYPT : ACT_DECRYPT;
                send_item(it, 1'b1, REFUSED_OUT);
            end
            else if (pick == 1)
            begin
                it.action = ACT_KEY;
                send_item(it, 1'b1, NONE_OUT);
            end
            it.action = ACT_KEY;
            if (full_key && i < CELLS)
                it.sym_a = 8'(perm[i]);
            else
                it.sym_a = 8'($urandom);
            send_item(it, 1'b1, NONE_OUT);
        end

        for (int r = PRE_ROWS; r < PLAN_ROWS; r++)
            send_item(plan[r].item, plan[r].typed, plan[r].want);

        // random pairs: shared rows and columns, doubled bytes, round trips
        for (int n = 0; n < PAIR_ITEMS; n++)
        begin
            calm = (n >= 600 && n < 800);
            if (n == 300)
                hold_request = 1'b1;
            a    = 8'($urandom);
            p    = cell_of(a);
            mode = $urandom_range(0, 9);
            miss = ($urandom_range(0, 6) == 0);
            case (mode)
                4, 5:    b = sq_model[(p / SIDE) * SIDE + $urandom_range(0, SIDE - 1)];
                6, 7:    b = sq_model[$urandom_range(0, SIDE - 1) * SIDE + p % SIDE];
                8:       b = a;
                default: b = 8'($urandom);
            endcase
            it.sym_a     = a;
            it.sym_b     = b;
            it.b_missing = miss;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                it.action = ACT_ENCRYPT;
            else if (pick < 7)
            begin
                // decrypt a sealed pair so the pad restore paths are hit
                seal_pair(a, b, miss, ca, cb);
                it.action    = ACT_DECRYPT;
                it.sym_a     = ca;
                it.sym_b     = cb;
                it.b_missing = 1'($urandom_range(0, 1));
            end
            else if (pick < 9)
                it.action = ACT_DECRYPT;
            else
                it.action = ($urandom_range(0, 1) != 0) ? ACT_KEY : ACT_FINISH;
            send_item(it, 1'b0, NONE_OUT);
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // drain
        while (cipher_result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpc_pkg.sv
rtl/bpc_pair_rule.sv
rtl/byte_playfair_cipher_16x16.sv
sim/tb_top.sv
